/* hdl/dpd_pkg.sv */
// Shared types, constants and the drive-shaping helper function for the dual PD drive controller.
`timescale 1ns / 1ps

package dpd_pkg;

	localparam int CountW = 16;
	localparam int GainW  = 16;
	localparam int DriveW = 16;
	localparam int ErrW   = 18;
	localparam int SettleW = 20;
	localparam int CorrW  = 34;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 20;

	localparam int FracShift = 5;
	localparam int DriveMax  = 32767;
	localparam int DriveMin  = -32768;
	localparam int DeadLimit = 9830;
	localparam int DeadFloor = 11469;
	localparam int Tol       = 10;

	localparam logic [SettleW-1:0] CountTop = '1;

	typedef enum logic [CfgIdxW-1:0] {
		REG_GAIN_P_ANGLE     = 3'd0,
		REG_GAIN_D_ANGLE     = 3'd1,
		REG_GAIN_P_DISTANCE  = 3'd2,
		REG_GAIN_D_DISTANCE  = 3'd3,
		REG_TARGET_DISTANCE  = 3'd4,
		REG_TARGET_ANGLE     = 3'd5,
		REG_SETTLE_THRESHOLD = 3'd6
	} cfg_reg_t;

	localparam logic [GainW-1:0]   GainAngleRst    = 16'd1573;
	localparam logic [GainW-1:0]   GainDistanceRst = 16'd1363;
	localparam logic [SettleW-1:0] SettleThreshRst = 20'd500000;

	typedef logic signed [CorrW-1:0] corr_t;
	typedef logic signed [DriveW-1:0] drive_t;

	// Saturate to Q1.15, then push small nonzero drives out to the minimum level.
	function automatic drive_t shape_drive(input corr_t v);
		drive_t d;
		if (v > corr_t'(DriveMax)) begin
			d = drive_t'(DriveMax);
		end else if (v < corr_t'(DriveMin)) begin
			d = drive_t'(DriveMin);
		end else begin
			d = drive_t'(v);
		end
		if (d > drive_t'(0) && d <= drive_t'(DeadLimit)) begin
			d = drive_t'(DeadFloor);
		end else if (d < drive_t'(0) && d >= drive_t'(-DeadLimit)) begin
			d = drive_t'(-DeadFloor);
		end
		return d;
	endfunction

endpackage

/* hdl/dpd_if.sv */
// Handshake interfaces for the encoder, drive and configuration channels.
`timescale 1ns / 1ps

interface dpd_enc_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [dpd_pkg::CountW-1:0]         left_count;
	logic signed [dpd_pkg::CountW-1:0]         right_count;

	modport source (output valid, output left_count, output right_count, input ready);
	modport sink (input valid, input left_count, input right_count, output ready);
endinterface

interface dpd_drv_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [dpd_pkg::DriveW-1:0]         left_drive;
	logic signed [dpd_pkg::DriveW-1:0]         right_drive;
	logic                                      done_res;

	modport source (output valid, output left_drive, output right_drive, output done_res,
		input ready);
	modport sink (input valid, input left_drive, input right_drive, input done_res,
		output ready);
endinterface

interface dpd_cfg_if;
	logic                                      valid;
	logic                                      ready;
	logic [dpd_pkg::CfgIdxW-1:0]               index;
	logic [dpd_pkg::CfgDataW-1:0]              data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/dpd_pd_term.sv */
// Proportional and derivative products of one PD loop, scaled from Q.20 to Q.15.
`timescale 1ns / 1ps

module dpd_pd_term (
	input  logic signed [dpd_pkg::ErrW-1:0]  err,
	input  logic signed [dpd_pkg::ErrW-1:0]  prev_err,
	input  logic [dpd_pkg::GainW-1:0]        gain_p,
	input  logic [dpd_pkg::GainW-1:0]        gain_d,
	output dpd_pkg::corr_t                   term_p,
	output dpd_pkg::corr_t                   term_d
);

	localparam int EW = dpd_pkg::ErrW;
	localparam int GW = dpd_pkg::GainW;
	localparam int CW = dpd_pkg::CorrW;
	localparam int PW = EW + GW + 1;
	localparam int DW = EW + GW + 2;

	logic signed [EW:0]       err_diff;
	logic signed [PW-1:0]     prod_p;
	logic signed [DW-1:0]     prod_d;

	assign err_diff = {err[EW-1], err} - {prev_err[EW-1], prev_err};
	assign prod_p   = PW'(err) * PW'($signed({1'b0, gain_p}));
	assign prod_d   = DW'(err_diff) * DW'($signed({1'b0, gain_d}));

	// Arithmetic shifts floor the products toward minus infinity.
	assign term_p = CW'(prod_p >>> dpd_pkg::FracShift);
	assign term_d = CW'(prod_d >>> dpd_pkg::FracShift);

endmodule

/* hdl/dual_pd_drive_controller_unit.sv */
// Top level of the dual PD drive controller: errors, PD loops, drive shaping, settle detect.
`timescale 1ns / 1ps

// One encoder word is taken per clock while enc.ready is high; one drive word comes out per
// word taken, in order. The encoder word is registered on acceptance; once the output register
// is free, one combinational pass forms both errors, the four gain products, the saturated and
// shaped drives and the settle compare, and the result is loaded into the output register while
// the stored errors and settle count update. With the output stalled the block holds one result
// and one waiting encoder word before it drops input ready. Configuration writes are always
// accepted; they belong in idle periods.
module dual_pd_drive_controller_unit (
	input  logic clk,
	input  logic arst_n,
	dpd_enc_if.sink   enc,
	dpd_drv_if.source drv,
	dpd_cfg_if.sink   cfg
);

	localparam int CW = dpd_pkg::CountW;
	localparam int EW = dpd_pkg::ErrW;
	localparam int GW = dpd_pkg::GainW;
	localparam int SW = dpd_pkg::SettleW;

	localparam logic signed [EW-1:0] TolHi = EW'(dpd_pkg::Tol);
	localparam logic signed [EW-1:0] TolLo = EW'(-dpd_pkg::Tol);

	// Configuration registers.
	logic [GW-1:0]        gain_p_angle_q;
	logic [GW-1:0]        gain_d_angle_q;
	logic [GW-1:0]        gain_p_distance_q;
	logic [GW-1:0]        gain_d_distance_q;
	logic signed [CW-1:0] target_distance_q;
	logic signed [CW-1:0] target_angle_q;
	logic [SW-1:0]        settle_threshold_q;

	// Loop state.
	logic signed [EW-1:0] prev_angle_err_q;
	logic signed [EW-1:0] prev_dist_err_q;
	logic [SW-1:0]        settle_count_q;

	// Input and output registers.
	logic                 v_s1;
	logic signed [CW-1:0] left_s1;
	logic signed [CW-1:0] right_s1;
	logic                 out_valid_q;
	dpd_pkg::drive_t      left_drive_q;
	dpd_pkg::drive_t      right_drive_q;
	logic                 done_q;

	logic out_free;
	logic s1_move;
	logic s1_free;
	logic in_take;

	assign out_free = !out_valid_q || drv.ready;
	assign s1_move  = v_s1 && out_free;
	assign s1_free  = !v_s1 || out_free;
	assign in_take  = enc.valid && s1_free;

	assign enc.ready = s1_free;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_angle_q     <= dpd_pkg::GainAngleRst;
			gain_d_angle_q     <= dpd_pkg::GainAngleRst;
			gain_p_distance_q  <= dpd_pkg::GainDistanceRst;
			gain_d_distance_q  <= dpd_pkg::GainDistanceRst;
			target_distance_q  <= '0;
			target_angle_q     <= '0;
			settle_threshold_q <= dpd_pkg::SettleThreshRst;
		end else if (cfg.valid) begin
			case (dpd_pkg::cfg_reg_t'(cfg.index))
				dpd_pkg::REG_GAIN_P_ANGLE:     gain_p_angle_q     <= cfg.data[GW-1:0];
				dpd_pkg::REG_GAIN_D_ANGLE:     gain_d_angle_q     <= cfg.data[GW-1:0];
				dpd_pkg::REG_GAIN_P_DISTANCE:  gain_p_distance_q  <= cfg.data[GW-1:0];
				dpd_pkg::REG_GAIN_D_DISTANCE:  gain_d_distance_q  <= cfg.data[GW-1:0];
				dpd_pkg::REG_TARGET_DISTANCE:  target_distance_q  <= $signed(cfg.data[CW-1:0]);
				dpd_pkg::REG_TARGET_ANGLE:     target_angle_q     <= $signed(cfg.data[CW-1:0]);
				dpd_pkg::REG_SETTLE_THRESHOLD: settle_threshold_q <= cfg.data[SW-1:0];
				default: ;
			endcase
		end
	end

	// Error formation.
	logic signed [CW:0]   diff_rl;
	logic signed [CW:0]   sum_rl;
	logic signed [CW:0]   sum_adj;
	logic signed [CW:0]   half_sum;
	logic signed [EW-1:0] angle_err;
	logic signed [EW-1:0] dist_err;
	logic                 in_tol;
	logic [SW-1:0]        settle_next;

	assign diff_rl  = {right_s1[CW-1], right_s1} - {left_s1[CW-1], left_s1};
	assign sum_rl   = {right_s1[CW-1], right_s1} + {left_s1[CW-1], left_s1};
	// Adding one to a negative sum makes the shift truncate toward zero.
	assign sum_adj  = sum_rl + $signed({{CW{1'b0}}, sum_rl[CW]});
	assign half_sum = sum_adj >>> 1;
	assign angle_err = EW'(target_angle_q) - EW'(diff_rl);
	assign dist_err  = EW'(target_distance_q) - EW'(half_sum);

	assign in_tol = (angle_err >= TolLo) && (angle_err <= TolHi) &&
		(dist_err >= TolLo) && (dist_err <= TolHi);

	always_comb begin
		if (!in_tol) begin
			settle_next = '0;
		end else if (settle_count_q == dpd_pkg::CountTop) begin
			settle_next = settle_count_q;
		end else begin
			settle_next = settle_count_q + 1'b1;
		end
	end

	dpd_pkg::corr_t ang_p;
	dpd_pkg::corr_t ang_d;
	dpd_pkg::corr_t dist_p;
	dpd_pkg::corr_t dist_d;

	dpd_pd_term u_angle_term (
		.err      (angle_err),
		.prev_err (prev_angle_err_q),
		.gain_p   (gain_p_angle_q),
		.gain_d   (gain_d_angle_q),
		.term_p   (ang_p),
		.term_d   (ang_d)
	);

	dpd_pd_term u_dist_term (
		.err      (dist_err),
		.prev_err (prev_dist_err_q),
		.gain_p   (gain_p_distance_q),
		.gain_d   (gain_d_distance_q),
		.term_p   (dist_p),
		.term_d   (dist_d)
	);

	// Drive sums and shaping.
	dpd_pkg::corr_t ang_corr;
	dpd_pkg::corr_t dist_corr;
	dpd_pkg::drive_t left_drive_c;
	dpd_pkg::drive_t right_drive_c;

	assign ang_corr      = ang_p + ang_d;
	assign dist_corr     = dist_p + dist_d;
	assign left_drive_c  = dpd_pkg::shape_drive(dist_corr - ang_corr);
	assign right_drive_c = dpd_pkg::shape_drive(dist_corr + ang_corr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1             <= 1'b0;
			out_valid_q      <= 1'b0;
			prev_angle_err_q <= '0;
			prev_dist_err_q  <= '0;
			settle_count_q   <= '0;
		end else begin
			v_s1        <= in_take || (v_s1 && !out_free);
			out_valid_q <= s1_move || (out_valid_q && !drv.ready);
			// Loop state advances exactly once per word, as it moves to the output.
			if (s1_move) begin
				prev_angle_err_q <= angle_err;
				prev_dist_err_q  <= dist_err;
				settle_count_q   <= settle_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			left_s1  <= enc.left_count;
			right_s1 <= enc.right_count;
		end
		if (s1_move) begin
			left_drive_q  <= left_drive_c;
			right_drive_q <= right_drive_c;
			done_q        <= (settle_next == settle_threshold_q);
		end
	end

	assign drv.valid       = out_valid_q;
	assign drv.left_drive  = left_drive_q;
	assign drv.right_drive = right_drive_q;
	assign drv.done_res    = done_q;

endmodule
